### rtl/pdse_pkg.sv
// shared constants and types for the pulse distance sample encoder
package pdse_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] CfgHighUs    = 2'd0;
  localparam logic [1:0] CfgZeroLowUs = 2'd1;
  localparam logic [1:0] CfgOneLowUs  = 2'd2;

  // register reset values
  localparam logic [7:0] HighUsReset    = 8'd2;
  localparam logic [7:0] ZeroLowUsReset = 8'd3;
  localparam logic [7:0] OneLowUsReset  = 8'd8;

  // temperature side word
  localparam logic [15:0] WordMark     = 16'h0E00;
  localparam logic [4:0]  WordBits     = 5'd16;
  localparam logic [4:0]  BitCountInit = 5'd17;

  // frame layout: 9 bits, two segments each, one closing pulse
  localparam int unsigned FrameBits = 9;
  localparam logic [4:0]  LastSeg   = 5'd18;

  // one line segment
  typedef struct packed {
    logic       level;
    logic [7:0] duration;
    logic       last;
  } seg_t;

endpackage

### rtl/pulse_distance_sample_encoder_unit.sv
// pulse distance sample encoder: one sample in, nineteen line segments out
// an item's first segment goes from the frame register into the output register
// the output register gives one segment per cycle while the receiver is ready;
// the next item is taken while the closing segment of the previous one is loaded
// reset: registers return to 2/3/8, the side word reloads on the first item,
// and the frame and output registers come up empty
module pulse_distance_sample_encoder_unit import pdse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [11:0] sample, [19:12] temperature, [23:20] zero
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] level, [8:1] duration, [15:9] zero
  output logic        m_axis_tlast,   // last
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0] high_us_q, zero_low_us_q, one_low_us_q;
  logic [4:0] cnt_q, cnt_d;
  logic [15:0] temp_q, temp_d;
  logic [15:0] word;

  logic                 cur_valid_q, cur_valid_d;
  logic [FrameBits-1:0] cur_bits_q, cur_bits_d;
  logic [4:0]           seg_q, seg_d;

  logic out_valid_q, out_valid_d;
  seg_t out_q, out_d;

  logic adv, finish, accept;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_us_q     <= HighUsReset;
      zero_low_us_q <= ZeroLowUsReset;
      one_low_us_q  <= OneLowUsReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgHighUs:    high_us_q     <= cfg_data_i;
        CfgZeroLowUs: zero_low_us_q <= cfg_data_i;
        CfgOneLowUs:  one_low_us_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake control
  assign adv           = cur_valid_q && (!out_valid_q || m_axis_tready);
  assign finish        = adv && (seg_q == LastSeg);
  assign s_axis_tready = !cur_valid_q || finish;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // side word reload and shift on each accepted item
  always_comb begin
    if (cnt_q >= WordBits) begin
      word  = WordMark | {8'd0, s_axis_tdata[19:12]};
      cnt_d = 5'd1;
    end else begin
      word  = temp_q;
      cnt_d = cnt_q + 5'd1;
    end
    temp_d = {word[14:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= BitCountInit;
      temp_q <= '0;
    end else if (accept) begin
      cnt_q  <= cnt_d;
      temp_q <= temp_d;
    end
  end

  // frame register: bits go out MSB first from the top of a shift register
  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_bits_d  = cur_bits_q;
    seg_d       = seg_q;
    if (adv) begin
      seg_d = seg_q + 5'd1;
      if (seg_q[0]) begin
        cur_bits_d = {cur_bits_q[FrameBits-2:0], 1'b0};
      end
      if (finish) begin
        cur_valid_d = 1'b0;
      end
    end
    if (accept) begin
      cur_valid_d = 1'b1;
      cur_bits_d  = {s_axis_tdata[11:4], word[15]};
      seg_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      seg_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      seg_q       <= seg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_bits_q <= cur_bits_d;
  end

  // segment builder: even segments are high pulses, odd ones encode a bit
  always_comb begin
    out_d.last = (seg_q == LastSeg);
    if (seg_q[0]) begin
      out_d.level    = 1'b0;
      out_d.duration = cur_bits_q[FrameBits-1] ? one_low_us_q : zero_low_us_q;
    end else begin
      out_d.level    = 1'b1;
      out_d.duration = high_us_q;
    end
  end

  // output register
  assign out_valid_d = adv || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.duration, out_q.level};
  assign m_axis_tlast  = out_q.last;

endmodule

### tb/tb.sv
// testbench for the pulse distance sample encoder: directed and random stimulus, segment-level checking
`timescale 1ns / 1ps

module tb import pdse_pkg::*; ();

  // index past the end of the register list, writes to it are dropped
  localparam logic [1:0] CfgNone = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned StallCycles = 400;

  typedef struct packed {
    logic [11:0] sample;
    logic [7:0]  temp;
  } sample_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  // encoder model state
  logic [7:0]  high_len = HighUsReset;
  logic [7:0]  zero_gap = ZeroLowUsReset;
  logic [7:0]  one_gap = OneLowUsReset;
  logic [4:0]  side_count = BitCountInit;
  logic [15:0] side_word = '0;

  sample_item_t pending_samples[$];
  sample_item_t cur_item = '0;
  seg_t         segs_due[$];
  int unsigned  samples_queued = 0;
  int unsigned  samples_taken = 0;
  int unsigned  tx_gap = 0;
  int unsigned  rx_gap = 0;
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  logic         no_idle = 1'b0;
  logic         stall_req = 1'b0;
  logic         hold_rx = 1'b0;

  pulse_distance_sample_encoder_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [11:0] sample, [19:12] temperature, [23:20] zero
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] level, [8:1] duration, [15:9] zero
    .m_axis_tlast  (m_axis_tlast),   // last
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 19);
  endfunction

  // expected segments of one sample: 8 sample bits and a side bit, then a closing pulse
  function automatic void encode_frame(sample_item_t it);
    logic [8:0] frame_bits;
    logic       side;
    seg_t       seg;
    if (side_count >= WordBits) begin
      side_count = '0;
      side_word = WordMark | {8'h00, it.temp};
    end
    side = side_word[15];
    side_word = side_word << 1;
    side_count = side_count + 5'd1;
    frame_bits = {it.sample[11:4], side};
    for (int i = int'(FrameBits) - 1; i >= 0; i--) begin
      seg.level = 1'b1;
      seg.duration = high_len;
      seg.last = 1'b0;
      segs_due.push_back(seg);
      seg.level = 1'b0;
      seg.duration = frame_bits[i] ? one_gap : zero_gap;
      segs_due.push_back(seg);
    end
    seg.level = 1'b1;
    seg.duration = high_len;
    seg.last = 1'b1;
    segs_due.push_back(seg);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // sample driver
  always @(posedge clk_i) begin : sample_driver
    logic offer;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        encode_frame(cur_item);
        samples_taken++;
        offer = 1'b0;
        tx_gap = draw_gap();
      end
      if (!offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_samples.size() != 0) begin
          cur_item = pending_samples.pop_front();
          offer = 1'b1;
        end
      end
      s_axis_tvalid <= offer;
      s_axis_tdata <= {4'b0000, cur_item.temp, cur_item.sample};
    end
  end

  // segment monitor and receiver backpressure
  always @(posedge clk_i) begin : seg_monitor
    seg_t got;
    seg_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.level = m_axis_tdata[0];
        got.duration = m_axis_tdata[8:1];
        got.last = m_axis_tlast;
        if (segs_due.size() == 0) begin
          $display("%0t: unexpected segment, expected none, actual level %0b duration %0d last %0b",
                   $time, got.level, got.duration, got.last);
          errors++;
        end else begin
          want = segs_due.pop_front();
          check_field("level", 32'(want.level), 32'(got.level));
          check_field("duration", 32'(want.duration), 32'(got.duration));
          check_field("last", 32'(want.last), 32'(got.last));
        end
        rx_gap = draw_gap();
      end
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (stall_req);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (StallCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // register write, valid is left high for a following write
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgHighUs: begin
        high_len = val;
      end
      CfgZeroLowUs: begin
        zero_gap = val;
      end
      CfgOneLowUs: begin
        one_gap = val;
      end
      default: begin
      end
    endcase
  endtask

  task automatic write_all(logic [7:0] h, logic [7:0] z, logic [7:0] o);
    write_reg(CfgHighUs, h);
    write_reg(CfgZeroLowUs, z);
    write_reg(CfgOneLowUs, o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_sample(logic [11:0] smp, logic [7:0] tmp);
    sample_item_t it;
    it.sample = smp;
    it.temp = tmp;
    pending_samples.push_back(it);
    samples_queued++;
  endtask

  task automatic queue_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      queue_sample(12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (samples_taken != samples_queued || segs_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // test sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values, edge samples, a full side word and a reload
    queue_sample(12'h000, 8'h00);
    queue_sample(12'hFFF, 8'hFF);
    queue_sample(12'h800, 8'h5A);
    queue_sample(12'h00F, 8'hA5);
    queue_sample(12'hAAA, 8'hFF);
    queue_sample(12'h555, 8'h00);
    queue_sample(12'hFF0, 8'h12);
    queue_sample(12'h010, 8'h34);
    for (int i = 0; i < 8; i++) queue_sample(12'(12'h7F8 ^ (12'h111 * i)), 8'h00);
    // count reaches sixteen here, so this temperature goes into the reloaded word
    queue_sample(12'h123, 8'hFF);
    queue_sample(12'hFFF, 8'h80);
    queue_sample(12'h000, 8'h01);
    queue_sample(12'hC3C, 8'h7E);
    wait_idle();

    // longest high pulse, shortest nonzero zero gap, longest one gap
    write_all(8'd255, 8'd1, 8'd255);
    queue_random(50);
    wait_idle();

    // zero-length segments, a dropped write past the list, receiver hold-off
    write_all(8'd0, 8'd0, 8'd0);
    write_reg(CfgNone, 8'h55);
    cfg_valid_i <= 1'b0;
    stall_req = 1'b1;
    queue_random(40);
    wait_idle();

    // back to back with no idling on either side
    no_idle = 1'b1;
    write_all(8'd1, 8'd255, 8'd1);
    queue_random(50);
    wait_idle();
    no_idle = 1'b0;

    // random register settings
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CfgNone, 8'($urandom_range(0, 255)));
      write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
      queue_random(15);
      wait_idle();
    end

    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
